[hw/rtl/stereo_linear_interp_resampler_defines.svh]
// assertion macros for the resampler, clocked on clk with rst_n held low as reset
`ifndef STEREO_LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define STEREO_LINEAR_INTERP_RESAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLIR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLIR_ASSERT(lbl, prop, msg)
`define SLIR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/slir_pkg.sv]
package slir_pkg;

    localparam int FRAC_WIDTH = 14;
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int STEP_W     = 21;
    // phase stays below one plus the largest clamped step
    localparam int PHASE_W    = FRAC_WIDTH + 7;
    localparam int PROD_W     = DIFF_W + FRAC_WIDTH + 1;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_WIDTH;
    localparam int STEP_MIN = (1 << FRAC_WIDTH) >> 6;
    localparam int STEP_MAX = (1 << FRAC_WIDTH) << 6;

    localparam logic [STEP_W-1:0] STEP_RESET = 21'd16384;

    localparam logic CFG_IDX_PHASE_STEP = 1'b0;
    localparam logic CFG_IDX_INTERP     = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;

    typedef enum logic [1:0] {
        OP_LOAD_OLDER,
        OP_PRIME,
        OP_DUP,
        OP_SHIFT
    } op_t;

    typedef struct packed {
        op_t     op;
        sample_t left;
        sample_t right;
    } cmd_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
    } result_t;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic              interp_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // base + floor(diff * frac / ONE)
    function automatic sample_t lerp(input sample_t base, input diff_t diff,
                                     input logic [FRAC_WIDTH-1:0] frac);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        prod = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
        sum  = (prod >>> FRAC_WIDTH) + PROD_W'(base);
        return sum[SAMPLE_W-1:0];
    endfunction

endpackage

[hw/rtl/slir_front.sv]
module slir_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  slir_pkg::sample_t src_left,
    input  slir_pkg::sample_t src_right,
    input  logic              end_of_source,
    output logic              cmd_valid,
    output slir_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    logic [1:0]     prime_count_reg, prime_count_next;
    logic           stream_ended_reg, stream_ended_next;
    slir_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           accept;
    logic           q_write;
    slir_pkg::op_t  op;
    logic           do_pop;

    assign full   = (count_reg == 2'd2);
    assign accept = push && !full;

    // classify each frame against the priming progress
    always_comb
    begin
        prime_count_next  = prime_count_reg;
        stream_ended_next = stream_ended_reg;
        q_write           = 1'b0;
        op                = slir_pkg::OP_SHIFT;
        if (accept && !stream_ended_reg)
        begin
            case (prime_count_reg)
                2'd0:
                begin
                    if (end_of_source)
                        stream_ended_next = 1'b1;
                    else
                    begin
                        op               = slir_pkg::OP_LOAD_OLDER;
                        q_write          = 1'b1;
                        prime_count_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    q_write          = 1'b1;
                    prime_count_next = 2'd2;
                    if (end_of_source)
                    begin
                        op                = slir_pkg::OP_DUP;
                        stream_ended_next = 1'b1;
                    end
                    else
                        op = slir_pkg::OP_PRIME;
                end
                default:
                begin
                    if (end_of_source)
                        stream_ended_next = 1'b1;
                    else
                    begin
                        op      = slir_pkg::OP_SHIFT;
                        q_write = 1'b1;
                    end
                end
            endcase
        end
    end

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_count_reg  <= 2'd0;
            stream_ended_reg <= 1'b0;
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            count_reg        <= 2'd0;
        end
        else
        begin
            prime_count_reg  <= prime_count_next;
            stream_ended_reg <= stream_ended_next;
            if (q_write)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(q_write) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_write)
            q_reg[wr_ptr_reg] <= '{op: op, left: src_left, right: src_right};
    end

endmodule

[hw/rtl/slir_back.sv]
`include "stereo_linear_interp_resampler_defines.svh"

module slir_back (
    input  logic              clk,
    input  logic              rst_n,
    input  slir_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  slir_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output slir_pkg::result_t res
);

    slir_pkg::state_t              state_reg, state_next;
    slir_pkg::sample_t             older_left_reg, older_left_next;
    slir_pkg::sample_t             older_right_reg, older_right_next;
    slir_pkg::sample_t             newer_left_reg, newer_left_next;
    slir_pkg::sample_t             newer_right_reg, newer_right_next;
    slir_pkg::diff_t               diff_left_reg, diff_left_next;
    slir_pkg::diff_t               diff_right_reg, diff_right_next;
    logic [slir_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [slir_pkg::PHASE_W-1:0]  step_eff;
    logic [slir_pkg::PHASE_W-1:0]  phase_sum;
    logic [31:0]                   step_wide;
    logic                          run_last;

    // clamp step to one sixty-fourth .. sixty-four frames
    always_comb
    begin
        step_wide = 32'(cfg.phase_step);
        if (step_wide < 32'(slir_pkg::STEP_MIN))
            step_eff = slir_pkg::PHASE_W'(slir_pkg::STEP_MIN);
        else if (step_wide > 32'(slir_pkg::STEP_MAX))
            step_eff = slir_pkg::PHASE_W'(slir_pkg::STEP_MAX);
        else
            step_eff = slir_pkg::PHASE_W'(cfg.phase_step);
    end

    assign phase_sum = phase_reg + step_eff;
    assign run_last  = (phase_sum >= slir_pkg::PHASE_ONE);

    always_comb
    begin
        res.last  = run_last;
        if (cfg.interp_enable)
        begin
            res.left  = slir_pkg::lerp(older_left_reg, diff_left_reg,
                                       phase_reg[slir_pkg::FRAC_WIDTH-1:0]);
            res.right = slir_pkg::lerp(older_right_reg, diff_right_reg,
                                       phase_reg[slir_pkg::FRAC_WIDTH-1:0]);
        end
        else
        begin
            res.left  = older_left_reg;
            res.right = older_right_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        older_left_next  = older_left_reg;
        older_right_next = older_right_reg;
        newer_left_next  = newer_left_reg;
        newer_right_next = newer_right_reg;
        diff_left_next   = diff_left_reg;
        diff_right_next  = diff_right_reg;
        phase_next       = phase_reg;
        cmd_pop          = 1'b0;
        res_push         = 1'b0;
        case (state_reg)
            slir_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        slir_pkg::OP_LOAD_OLDER:
                        begin
                            older_left_next  = cmd.left;
                            older_right_next = cmd.right;
                        end
                        slir_pkg::OP_PRIME:
                        begin
                            newer_left_next  = cmd.left;
                            newer_right_next = cmd.right;
                            diff_left_next   = slir_pkg::DIFF_W'(cmd.left)
                                             - slir_pkg::DIFF_W'(older_left_reg);
                            diff_right_next  = slir_pkg::DIFF_W'(cmd.right)
                                             - slir_pkg::DIFF_W'(older_right_reg);
                            phase_next       = '0;
                            state_next       = slir_pkg::ST_EMIT;
                        end
                        slir_pkg::OP_DUP:
                        begin
                            newer_left_next  = older_left_reg;
                            newer_right_next = older_right_reg;
                            diff_left_next   = '0;
                            diff_right_next  = '0;
                            phase_next       = '0;
                            state_next       = slir_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            older_left_next  = newer_left_reg;
                            older_right_next = newer_right_reg;
                            newer_left_next  = cmd.left;
                            newer_right_next = cmd.right;
                            diff_left_next   = slir_pkg::DIFF_W'(cmd.left)
                                             - slir_pkg::DIFF_W'(newer_left_reg);
                            diff_right_next  = slir_pkg::DIFF_W'(cmd.right)
                                             - slir_pkg::DIFF_W'(newer_right_reg);
                            phase_next       = (phase_reg >= slir_pkg::PHASE_ONE)
                                             ? phase_reg - slir_pkg::PHASE_ONE : '0;
                            state_next       = slir_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            slir_pkg::ST_EMIT:
            begin
                if (phase_reg >= slir_pkg::PHASE_ONE)
                    state_next = slir_pkg::ST_IDLE;
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    phase_next = phase_sum;
                    if (run_last)
                        state_next = slir_pkg::ST_IDLE;
                end
            end
            default:
                state_next = slir_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= slir_pkg::ST_IDLE;
            older_left_reg  <= '0;
            older_right_reg <= '0;
            newer_left_reg  <= '0;
            newer_right_reg <= '0;
            diff_left_reg   <= '0;
            diff_right_reg  <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            older_left_reg  <= older_left_next;
            older_right_reg <= older_right_next;
            newer_left_reg  <= newer_left_next;
            newer_right_reg <= newer_right_next;
            diff_left_reg   <= diff_left_next;
            diff_right_reg  <= diff_right_next;
            phase_reg       <= phase_next;
        end
    end

    `SLIR_ASSERT(a_push_phase_below_one, res_push |-> (phase_reg < slir_pkg::PHASE_ONE), "frame emitted with phase at or above one")
    `SLIR_ASSERT(a_last_ends_run, (res_push && res.last) |=> (state_reg == slir_pkg::ST_IDLE), "run did not end after last frame")
    `SLIR_ASSERT(a_run_continues, (res_push && !res.last) |=> (state_reg == slir_pkg::ST_EMIT && phase_reg < slir_pkg::PHASE_ONE), "run ended without a last frame")
    `SLIR_ASSERT_NEVER(a_no_pop_while_emitting, cmd_pop && state_reg == slir_pkg::ST_EMIT, "command taken in the middle of a run")

endmodule

[hw/rtl/slir_outq.sv]
module slir_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  slir_pkg::result_t res_in,
    output logic              res_full,
    output logic              empty,
    input  logic              pop,
    output slir_pkg::result_t res_out
);

    slir_pkg::result_t q_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push, do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign res_out  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= res_in;
    end

endmodule

[hw/rtl/stereo_linear_interp_resampler.sv]
// stereo linear-interpolation resampler: source frames go in through push/full and output
// frames come out through empty/pop, both sides behaving like a queue. phase_step (register 0,
// unsigned 7.14, source frames per output frame) sets the ratio and is clamped in use to
// 1/64 .. 64; interp_enable (register 1) picks linear interpolation or hold of the older
// sample. the first frame gives nothing, the second and each later one give zero or more
// output frames, and last_of_run marks the final frame caused by a source frame. an end
// marker stops all output until reset (with just one frame seen, that frame is emitted).
// flow: the front takes one transfer per cycle, while not full, into a two-entry command
// queue. the back sequencer takes a command while idle and then emits its output frames, or
// passes through a closing step when a frame gives no output; it takes no new command until
// it is idle again. the first frame only loads the older sample, an end marker after a single
// frame is handled like a source frame, and any other end marker never reaches the back. a
// two-entry result queue lets a waiting output frame sit while the back keeps working; once it
// is full the back holds for every cycle that it stays full.
module stereo_linear_interp_resampler (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [slir_pkg::STEP_W-1:0]   cfg_data,
    // source side
    input  logic                          push,
    output logic                          full,
    input  slir_pkg::sample_t             src_left,
    input  slir_pkg::sample_t             src_right,
    input  logic                          end_of_source,
    // output side
    output logic                          empty,
    input  logic                          pop,
    output slir_pkg::sample_t             out_left,
    output slir_pkg::sample_t             out_right,
    output logic                          last_of_run
);

    // configuration registers, to be written only while the block is idle; the block does not enforce this
    slir_pkg::cfg_t    cfg_reg;

    // front to back command channel
    logic              cmd_valid;
    slir_pkg::cmd_t    cmd;
    logic              cmd_pop;

    // back to result queue
    logic              res_push;
    logic              res_full;
    slir_pkg::result_t res;
    slir_pkg::result_t res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step    <= slir_pkg::STEP_RESET;
            cfg_reg.interp_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                slir_pkg::CFG_IDX_PHASE_STEP: cfg_reg.phase_step    <= cfg_data;
                slir_pkg::CFG_IDX_INTERP:     cfg_reg.interp_enable <= cfg_data[0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: takes source transfers, tracks priming and end of stream
    slir_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .src_left      (src_left),
        .src_right     (src_right),
        .end_of_source (end_of_source),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // back: sample pair, phase accumulator and interpolation
    slir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue toward the consumer
    slir_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign out_left    = res_out.left;
    assign out_right   = res_out.right;
    assign last_of_run = res_out.last;

endmodule

[tb/sv/stereo_linear_interp_resampler_tb.sv]
// keeps a private copy of the resampler state and the frames it still owes
class resampler_scoreboard;

    typedef enum logic [1:0] {
        NO_FRAME,
        ONE_FRAME,
        PAIR_READY
    } prime_t;

    logic [slir_pkg::STEP_W-1:0]  step_reg;
    logic                         interp_on;
    slir_pkg::sample_t            older_l;
    slir_pkg::sample_t            older_r;
    slir_pkg::sample_t            newer_l;
    slir_pkg::sample_t            newer_r;
    logic [slir_pkg::PHASE_W-1:0] phase;
    prime_t                       primed;
    logic                         ended;
    slir_pkg::result_t            frames_due[$];
    int unsigned                  mismatches;

    function new();
        step_reg   = slir_pkg::STEP_RESET;
        interp_on  = 1'b1;
        older_l    = '0;
        older_r    = '0;
        newer_l    = '0;
        newer_r    = '0;
        phase      = '0;
        primed     = NO_FRAME;
        ended      = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [slir_pkg::STEP_W-1:0] data);
        if (idx == slir_pkg::CFG_IDX_PHASE_STEP)
            step_reg = data;
        else
            interp_on = data[0];
    endfunction

    // a + floor((b - a) * frac / one)
    function slir_pkg::sample_t blend(slir_pkg::sample_t a, slir_pkg::sample_t b,
                                      logic [slir_pkg::PHASE_W-1:0] frac);
        int diff;
        int prod;
        diff = int'(b) - int'(a);
        prod = diff * int'(frac);
        return slir_pkg::sample_t'(int'(a) + (prod >>> slir_pkg::FRAC_WIDTH));
    endfunction

    function void emit_frames();
        logic [slir_pkg::STEP_W-1:0]  step;
        logic [slir_pkg::PHASE_W-1:0] next_phase;
        slir_pkg::result_t            f;
        step = step_reg;
        if (step < slir_pkg::STEP_W'(slir_pkg::STEP_MIN))
            step = slir_pkg::STEP_W'(slir_pkg::STEP_MIN);
        if (step > slir_pkg::STEP_W'(slir_pkg::STEP_MAX))
            step = slir_pkg::STEP_W'(slir_pkg::STEP_MAX);
        while (phase < slir_pkg::PHASE_ONE)
        begin
            f.left     = interp_on ? blend(older_l, newer_l, phase) : older_l;
            f.right    = interp_on ? blend(older_r, newer_r, phase) : older_r;
            next_phase = phase + slir_pkg::PHASE_W'(step);
            f.last     = (next_phase >= slir_pkg::PHASE_ONE);
            frames_due.push_back(f);
            phase = next_phase;
        end
    endfunction

    function void note_input(slir_pkg::sample_t l, slir_pkg::sample_t r, logic eos);
        if (ended)
            return;
        case (primed)
            NO_FRAME:
            begin
                if (eos)
                    ended = 1'b1;
                else
                begin
                    older_l = l;
                    older_r = r;
                    primed  = ONE_FRAME;
                end
            end
            ONE_FRAME:
            begin
                newer_l = eos ? older_l : l;
                newer_r = eos ? older_r : r;
                primed  = PAIR_READY;
                phase   = '0;
                emit_frames();
                if (eos)
                    ended = 1'b1;
            end
            default:
            begin
                if (eos)
                    ended = 1'b1;
                else
                begin
                    older_l = newer_l;
                    older_r = newer_r;
                    newer_l = l;
                    newer_r = r;
                    phase   = (phase >= slir_pkg::PHASE_ONE)
                            ? phase - slir_pkg::PHASE_ONE : '0;
                    emit_frames();
                end
            end
        endcase
    endfunction

    function void check_result(slir_pkg::sample_t l, slir_pkg::sample_t r, logic last);
        slir_pkg::result_t want;
        if (frames_due.size() == 0)
        begin
            $error("output frame with nothing expected: left %0d right %0d", l, r);
            mismatches++;
            return;
        end
        want = frames_due.pop_front();
        if (l !== want.left)
        begin
            $error("out_left mismatch: expected %0d, actual %0d", want.left, l);
            mismatches++;
        end
        if (r !== want.right)
        begin
            $error("out_right mismatch: expected %0d, actual %0d", want.right, r);
            mismatches++;
        end
        if (last !== want.last)
        begin
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, last);
            mismatches++;
        end
    endfunction

    function int pending();
        return frames_due.size();
    endfunction

endclass

module stereo_linear_interp_resampler_tb;

    // generous bound on the whole run, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // cycles to let a frame that yields no output finish inside the block
    localparam int          SETTLE_CYCLES = 16;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic                        cfg_index;
    logic [slir_pkg::STEP_W-1:0] cfg_data;
    logic                        push;
    logic                        full;
    slir_pkg::sample_t           src_left;
    slir_pkg::sample_t           src_right;
    logic                        end_of_source;
    logic                        empty;
    logic                        pop;
    slir_pkg::sample_t           out_left;
    slir_pkg::sample_t           out_right;
    logic                        last_of_run;

    resampler_scoreboard sb;

    // idle chance in percent for each side, changed between test phases
    int          send_idle;
    int          recv_idle;
    int unsigned cycle_count;

    stereo_linear_interp_resampler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .src_left      (src_left),
        .src_right     (src_right),
        .end_of_source (end_of_source),
        .empty         (empty),
        .pop           (pop),
        .out_left      (out_left),
        .out_right     (out_right),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // run-away guard
    initial
    begin
        cycle_count = 0;
        wait (cycle_count == CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // monitor: values read right after the rising edge are the pre-edge values;
    // the output transfer is checked before the input transfer of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(out_left, out_right, last_of_run);
            if (push && !full)
                sb.note_input(src_left, src_right, end_of_source);
        end
    end

    // receiver: pop decided once per falling edge
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // mostly full-range noise, with the rails and values near zero mixed in
    function automatic slir_pkg::sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return slir_pkg::sample_t'(16'h8000);
            1:       return slir_pkg::sample_t'(16'h7FFF);
            2:       return slir_pkg::sample_t'($urandom_range(0, 15))
                          - slir_pkg::sample_t'(8);
            default: return slir_pkg::sample_t'($urandom);
        endcase
    endfunction

    // one source transfer; entered and left just after a falling edge, and push
    // stays high when the next frame follows with no gap
    task automatic send_frame(slir_pkg::sample_t l, slir_pkg::sample_t r, logic eos);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push          = 1'b1;
        src_left      = l;
        src_right     = r;
        end_of_source = eos;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending, wait for every owed frame, then let the block settle
    task automatic wait_drained();
        push = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [slir_pkg::STEP_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    // registers only change while the block is idle; upper data bits of the
    // interpolation write are noise
    task automatic configure(logic [slir_pkg::STEP_W-1:0] step, logic interp);
        wait_drained();
        write_reg(slir_pkg::CFG_IDX_PHASE_STEP, step);
        write_reg(slir_pkg::CFG_IDX_INTERP, {20'($urandom), interp});
        cfg_write = 1'b0;
    endtask

    // a random setting followed by a run of random frames
    task automatic random_segment(int items);
        logic [slir_pkg::STEP_W-1:0] step;
        case ($urandom_range(0, 4))
            0:       step = slir_pkg::STEP_W'($urandom_range(256, 2048));
            1, 2:    step = slir_pkg::STEP_W'($urandom_range(2048, 16384));
            3:       step = slir_pkg::STEP_W'($urandom_range(16384, 49152));
            default: step = slir_pkg::STEP_W'($urandom_range(0, 255));
        endcase
        configure(step, 1'($urandom_range(0, 1)));
        repeat (items) send_frame(rand_sample(), rand_sample(), 1'b0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = slir_pkg::CFG_IDX_PHASE_STEP;
        cfg_data      = '0;
        push          = 1'b0;
        src_left      = '0;
        src_right     = '0;
        end_of_source = 1'b0;
        sb            = new();

        // first phase: sender rarely idle, receiver often stalls
        send_idle = 9;
        recv_idle = 52;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting, unity ratio: priming frame gives nothing, then one frame each
        send_frame(slir_pkg::sample_t'(16'h8000), slir_pkg::sample_t'(16'h7FFF), 1'b0);
        send_frame(slir_pkg::sample_t'(16'h7FFF), slir_pkg::sample_t'(16'h8000), 1'b0);
        send_frame(slir_pkg::sample_t'(0), slir_pkg::sample_t'(-1), 1'b0);
        send_frame(slir_pkg::sample_t'(-1), slir_pkg::sample_t'(0), 1'b0);

        // quarter step, interpolation across full-scale swings
        configure(slir_pkg::STEP_W'(4096), 1'b1);
        send_frame(slir_pkg::sample_t'(16'h7FFF), slir_pkg::sample_t'(16'h8000), 1'b0);
        send_frame(slir_pkg::sample_t'(16'h8000), slir_pkg::sample_t'(16'h7FFF), 1'b0);
        send_frame(slir_pkg::sample_t'(16'h8000), slir_pkg::sample_t'(16'h8000), 1'b0);

        // same step, hold of the older sample
        configure(slir_pkg::STEP_W'(4096), 1'b0);
        send_frame(slir_pkg::sample_t'(16'h7FFF), slir_pkg::sample_t'(16'h7FFF), 1'b0);
        send_frame(slir_pkg::sample_t'(16'h8000), slir_pkg::sample_t'(16'h8000), 1'b0);

        // zero step is clamped up to the 1/64 limit
        configure('0, 1'b1);
        send_frame(slir_pkg::sample_t'(16'h7FFF), slir_pkg::sample_t'(16'h8000), 1'b0);
        send_frame(slir_pkg::sample_t'(16'h8000), slir_pkg::sample_t'(16'h7FFF), 1'b0);

        // just below and exactly at the lower clamp
        configure(slir_pkg::STEP_W'(255), 1'b1);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        configure(slir_pkg::STEP_W'(256), 1'b1);
        send_frame(rand_sample(), rand_sample(), 1'b0);

        // step of one and a half: some frames yield no output
        configure(slir_pkg::STEP_W'(24576), 1'b1);
        repeat (4) send_frame(rand_sample(), rand_sample(), 1'b0);

        repeat (2) random_segment(25);

        // second phase: sender often idle, receiver rarely stalls
        send_idle = 52;
        recv_idle = 9;
        repeat (2) random_segment(25);

        // third phase: both sides at full rate
        send_idle = 0;
        recv_idle = 0;
        repeat (2) random_segment(25);

        // all-ones step is clamped to 64: output comes back after 64 frames
        configure('1, 1'b1);
        repeat (68) send_frame(rand_sample(), rand_sample(), 1'b0);

        // upper clamp value written exactly
        configure(slir_pkg::STEP_W'(slir_pkg::STEP_MAX), 1'b0);
        repeat (4) send_frame(rand_sample(), rand_sample(), 1'b0);

        // end marker with the pair primed, then frames the block must ignore
        send_frame(rand_sample(), rand_sample(), 1'b1);
        repeat (4) send_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));

        wait_drained();
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
